FILE: sv/tamg_pkg.sv
// ----------------------------------------------------------------------------
// tamg_pkg
// Shared widths, codes, sideband types and helpers of the torus arc
// mesh generator.
// ----------------------------------------------------------------------------
package tamg_pkg;

  localparam int CNT_W     = 9;
  localparam int ANG_W     = 16;
  localparam int RAD_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 19;
  localparam int NORM_W    = 16;
  localparam int TEX_W     = 17;
  localparam int IDX_W     = 17;

  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_MAX_SIDES    = 256;

  localparam logic [RAD_W-1:0] RST_MAJOR = RAD_W'(256);
  localparam logic [RAD_W-1:0] RST_TUBE  = RAD_W'(64);
  localparam logic [CFG_W-1:0] RST_START = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_END   = CFG_W'(65536);
  localparam logic [CNT_W-1:0] RST_SEGS  = CNT_W'(16);
  localparam logic [CNT_W-1:0] RST_SIDES = CNT_W'(8);

  // divider: restoring, DIV_BITS quotient bits per stage
  localparam int PROD_W     = 42;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 11;
  localparam int NUM_W      = DIV_BITS * DIV_STAGES;
  localparam int DEN_W      = CNT_W;
  localparam int DIV_LANES  = 3;
  localparam int LANE_T     = 0;
  localparam int LANE_U     = 1;
  localparam int LANE_V     = 2;

  // sine/cosine lanes
  localparam int SC_LANES  = 4;
  localparam int SC_STAGES = 5;
  localparam int LANE_CT   = 0;
  localparam int LANE_ST   = 1;
  localparam int LANE_CP   = 2;
  localparam int LANE_SP   = 3;
  localparam int Z_W       = 15;
  localparam int SIN_QTR   = 16384;
  localparam int SIN_C1    = 1160;
  localparam int SIN_C2    = 10512;
  localparam int SIN_C3    = 25736;

  localparam int GEO_STAGES = 3;
  localparam int QUAD_LAST  = 5;
  localparam int K_W        = 3;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_QUAD   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAJOR = 3'd0,
    REG_TUBE  = 3'd1,
    REG_START = 3'd2,
    REG_END   = 3'd3,
    REG_SEGS  = 3'd4,
    REG_SIDES = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_c;
    logic             neg;
  } div_side_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_c;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } vtx_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
  } div_lane_t;

  function automatic logic [CNT_W-1:0] limit_count(logic [CNT_W-1:0] v, int maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > maxv) begin
      r = CNT_W'(maxv);
    end
    return r;
  endfunction

  // DIV_BITS steps of restoring division; quotient bits shift in at the bottom
  function automatic div_lane_t div_steps(div_lane_t x, logic [DEN_W-1:0] den);
    div_lane_t    y;
    logic [DEN_W:0] r;
    y = x;
    for (int b = 0; b < DIV_BITS; b++) begin
      r     = {y.rem, y.num[NUM_W-1]};
      y.num = {y.num[NUM_W-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r        = r - {1'b0, den};
        y.num[0] = 1'b1;
      end
      y.rem = r[DEN_W-1:0];
    end
    return y;
  endfunction

endpackage

FILE: sv/tamg_divider.sv
// ----------------------------------------------------------------------------
// tamg_divider
// Pipelined restoring divider, three lanes in lockstep, DIV_BITS quotient
// bits per stage.
// ----------------------------------------------------------------------------
module tamg_divider
  import tamg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num [DIV_LANES],
  input  logic [DEN_W-1:0] den    [DIV_LANES],
  input  div_side_t        in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] out_quo [DIV_LANES],
  output div_side_t        out_side
);

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] en;
  div_lane_t             lane_r [DIV_STAGES][DIV_LANES];
  div_side_t             side_r [DIV_STAGES];

  always_comb begin
    en[DIV_STAGES-1] = !v_r[DIV_STAGES-1] || out_ready;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= in_side;
      for (int l = 0; l < DIV_LANES; l++) begin
        lane_r[0][l] <= div_steps('{rem: '0, num: in_num[l]}, den[l]);
      end
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
        for (int l = 0; l < DIV_LANES; l++) begin
          lane_r[k][l] <= div_steps(lane_r[k-1][l], den[l]);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      out_quo[l] = lane_r[DIV_STAGES-1][l].num;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

FILE: sv/tamg_sincos.sv
// ----------------------------------------------------------------------------
// tamg_sincos
// Four-lane pipelined sine: quadrant fold, then the quarter-wave polynomial,
// one multiply per stage.
// ----------------------------------------------------------------------------
module tamg_sincos
  import tamg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ANG_W-1:0]         in_ang [SC_LANES],
  input  vtx_side_t                in_side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NORM_W-1:0] out_sin [SC_LANES],
  output vtx_side_t                out_side
);

  logic [SC_STAGES-1:0] v_r;
  logic [SC_STAGES-1:0] en;
  vtx_side_t            side_r [SC_STAGES];

  logic [Z_W-1:0]          z0_r [SC_LANES], z1_r [SC_LANES], z2_r [SC_LANES], z3_r [SC_LANES];
  logic [SC_LANES-1:0]     neg0_r, neg1_r, neg2_r, neg3_r;
  logic [Z_W-1:0]          zsq1_r [SC_LANES], zsq2_r [SC_LANES];
  logic [13:0]             t2_r [SC_LANES];
  logic [Z_W-1:0]          t4_r [SC_LANES];
  logic signed [NORM_W-1:0] s_r [SC_LANES];

  logic [Z_W-1:0]           z0_nxt   [SC_LANES];
  logic [SC_LANES-1:0]      neg0_nxt;
  logic [29:0]              sq       [SC_LANES];
  logic [25:0]              p1       [SC_LANES];
  logic [28:0]              p2       [SC_LANES];
  logic [29:0]              p3       [SC_LANES];
  logic [15:0]              s_mag    [SC_LANES];
  logic [Z_W-1:0]           zsq1_nxt [SC_LANES];
  logic [13:0]              t2_nxt   [SC_LANES];
  logic [Z_W-1:0]           t4_nxt   [SC_LANES];
  logic signed [NORM_W-1:0] s_nxt    [SC_LANES];

  always_comb begin
    en[SC_STAGES-1] = !v_r[SC_STAGES-1] || out_ready;
    for (int k = SC_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    for (int l = 0; l < SC_LANES; l++) begin
      // odd quadrants mirror the argument, upper half negates
      z0_nxt[l]   = in_ang[l][14] ? Z_W'(SIN_QTR) - {1'b0, in_ang[l][13:0]}
                                  : {1'b0, in_ang[l][13:0]};
      neg0_nxt[l] = in_ang[l][15];
      sq[l]       = 30'(z0_r[l]) * 30'(z0_r[l]);
      zsq1_nxt[l] = sq[l][28:14];
      p1[l]       = 26'(SIN_C1) * 26'(zsq1_r[l]);
      t2_nxt[l]   = 14'(SIN_C2) - {2'b0, p1[l][25:14]};
      p2[l]       = 29'(t2_r[l]) * 29'(zsq2_r[l]);
      t4_nxt[l]   = Z_W'(SIN_C3) - p2[l][28:14];
      p3[l]       = 30'(t4_r[l]) * 30'(z3_r[l]);
      s_mag[l]    = (p3[l][29:14] > 16'(SIN_QTR)) ? 16'(SIN_QTR) : p3[l][29:14];
      s_nxt[l]    = neg3_r[l] ? -$signed(s_mag[l]) : $signed(s_mag[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < SC_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= in_side;
      z0_r      <= z0_nxt;
      neg0_r    <= neg0_nxt;
    end
    if (en[1]) begin
      side_r[1] <= side_r[0];
      z1_r      <= z0_r;
      neg1_r    <= neg0_r;
      zsq1_r    <= zsq1_nxt;
    end
    if (en[2]) begin
      side_r[2] <= side_r[1];
      z2_r      <= z1_r;
      neg2_r    <= neg1_r;
      zsq2_r    <= zsq1_r;
      t2_r      <= t2_nxt;
    end
    if (en[3]) begin
      side_r[3] <= side_r[2];
      z3_r      <= z2_r;
      neg3_r    <= neg2_r;
      t4_r      <= t4_nxt;
    end
    if (en[4]) begin
      side_r[4] <= side_r[3];
      s_r       <= s_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[SC_STAGES-1];
  assign out_side  = side_r[SC_STAGES-1];
  assign out_sin   = s_r;

endmodule

FILE: sv/tamg_geom.sv
// ----------------------------------------------------------------------------
// tamg_geom
// Position and normal: radius and products, sweep rotation, rounding.
// ----------------------------------------------------------------------------
module tamg_geom
  import tamg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [NORM_W-1:0] in_trig [SC_LANES],
  input  vtx_side_t                in_side,
  input  logic [RAD_W-1:0]         major_radius,
  input  logic [RAD_W-1:0]         tube_radius,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [NORM_W-1:0] norm_x,
  output logic signed [NORM_W-1:0] norm_y,
  output logic signed [NORM_W-1:0] norm_z,
  output vtx_side_t                out_side
);

  localparam logic [49:0] RND28 = 50'd1 << 27;
  localparam logic [33:0] RND14 = 34'd1 << 13;

  logic [GEO_STAGES-1:0] v_r;
  logic [GEO_STAGES-1:0] en;
  vtx_side_t             side_r [GEO_STAGES];

  logic signed [32:0]       r0_r, pz0_r;
  logic signed [31:0]       nx0_r, ny0_r;
  logic signed [NORM_W-1:0] ct0_r, st0_r, sp0_r;
  logic signed [48:0]       px1_r, py1_r;
  logic signed [32:0]       pz1_r;
  logic signed [31:0]       nx1_r, ny1_r;
  logic signed [NORM_W-1:0] sp1_r;
  logic signed [POS_W-1:0]  px2_r, py2_r, pz2_r;
  logic signed [NORM_W-1:0] nx2_r, ny2_r, nz2_r;

  logic signed [32:0] r0_nxt, pz0_nxt;
  logic signed [31:0] nx0_nxt, ny0_nxt;
  logic signed [48:0] px1_nxt, py1_nxt;
  logic [49:0]        px_sum, py_sum;
  logic [33:0]        pz_sum;
  logic [32:0]        nx_sum, ny_sum;

  always_comb begin
    en[GEO_STAGES-1] = !v_r[GEO_STAGES-1] || out_ready;
    for (int k = GEO_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    // R in Q19.14 (33-bit signed)
    r0_nxt  = $signed({3'b0, major_radius, 14'b0})
              + $signed({1'b0, tube_radius}) * in_trig[LANE_CP];
    pz0_nxt = $signed({1'b0, tube_radius}) * in_trig[LANE_SP];
    nx0_nxt = in_trig[LANE_CT] * in_trig[LANE_CP];
    ny0_nxt = in_trig[LANE_ST] * in_trig[LANE_CP];
    px1_nxt = r0_r * ct0_r;
    py1_nxt = r0_r * st0_r;
    px_sum  = {px1_r[48], px1_r} + RND28;
    py_sum  = {py1_r[48], py1_r} + RND28;
    pz_sum  = {pz1_r[32], pz1_r} + RND14;
    nx_sum  = {nx1_r[31], nx1_r} + RND14[32:0];
    ny_sum  = {ny1_r[31], ny1_r} + RND14[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < GEO_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= in_side;
      r0_r      <= r0_nxt;
      pz0_r     <= pz0_nxt;
      nx0_r     <= nx0_nxt;
      ny0_r     <= ny0_nxt;
      ct0_r     <= in_trig[LANE_CT];
      st0_r     <= in_trig[LANE_ST];
      sp0_r     <= in_trig[LANE_SP];
    end
    if (en[1]) begin
      side_r[1] <= side_r[0];
      px1_r     <= px1_nxt;
      py1_r     <= py1_nxt;
      pz1_r     <= pz0_r;
      nx1_r     <= nx0_r;
      ny1_r     <= ny0_r;
      sp1_r     <= sp0_r;
    end
    if (en[2]) begin
      side_r[2] <= side_r[1];
      px2_r     <= px_sum[46:28];
      py2_r     <= py_sum[46:28];
      pz2_r     <= pz_sum[32:14];
      nx2_r     <= nx_sum[29:14];
      ny2_r     <= ny_sum[29:14];
      nz2_r     <= sp1_r;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[GEO_STAGES-1];
  assign out_side  = side_r[GEO_STAGES-1];
  assign pos_x     = px2_r;
  assign pos_y     = py2_r;
  assign pos_z     = pz2_r;
  assign norm_x    = nx2_r;
  assign norm_y    = ny2_r;
  assign norm_z    = nz2_r;

endmodule

FILE: sv/torus_arc_mesh_generator.sv
// ----------------------------------------------------------------------------
// torus_arc_mesh_generator
// Fixed-point torus arc tessellation: vertex attributes and quad indices.
// ----------------------------------------------------------------------------
// channel | ports                          | request per handshake
// in      | in_valid / in_stall            | command, ring, side
// out     | out_valid / out_stall          | one vertex or one triangle index
// cfg     | cfg_wr_en, cfg_index, cfg_wdata | one register write
//
// One request enters per cycle unless in_stall is high. The pipeline runs through the
// 11-stage divider (4 quotient bits per stage) and the 5-stage sine unit.
// A vertex leaves one result, a quad holds the output register for six results.
// Synchronous active-low reset clears valids and loads register defaults.
// Stalls back up stage by stage; empty stages keep filling.
// ----------------------------------------------------------------------------
module torus_arc_mesh_generator
  import tamg_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_SIDES    = DEF_MAX_SIDES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [0:0]               in_command,
  input  logic [CNT_W-1:0]         in_ring_index,
  input  logic [CNT_W-1:0]         in_side_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic signed [POS_W-1:0]  out_pos_z,
  output logic signed [NORM_W-1:0] out_norm_x,
  output logic signed [NORM_W-1:0] out_norm_y,
  output logic signed [NORM_W-1:0] out_norm_z,
  output logic [TEX_W-1:0]         out_tex_u,
  output logic [TEX_W-1:0]         out_tex_v,
  output logic [IDX_W-1:0]         out_vertex_index,
  output logic                     out_last
);

  // configuration
  logic [RAD_W-1:0] major_r, tube_r;
  logic [CFG_W-1:0] start_r, end_r;
  logic [CNT_W-1:0] segs_r, sides_r;
  logic signed [32:0] diff_r;
  logic [CNT_W-1:0] seg_cnt, side_cnt;
  logic [CNT_W:0]   row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r <= RST_MAJOR;
      tube_r  <= RST_TUBE;
      start_r <= RST_START;
      end_r   <= RST_END;
      segs_r  <= RST_SEGS;
      sides_r <= RST_SIDES;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAJOR: major_r <= cfg_wdata[RAD_W-1:0];
        REG_TUBE:  tube_r  <= cfg_wdata[RAD_W-1:0];
        REG_START: start_r <= cfg_wdata;
        REG_END:   end_r   <= cfg_wdata;
        REG_SEGS:  segs_r  <= cfg_wdata[CNT_W-1:0];
        REG_SIDES: sides_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= $signed({end_r[CFG_W-1], end_r}) - $signed({start_r[CFG_W-1], start_r});
  end

  assign seg_cnt  = limit_count(segs_r, MAX_SEGMENTS);
  assign side_cnt = limit_count(sides_r, MAX_SIDES);
  assign row      = {1'b0, side_cnt} + 1'b1;

  // front stages
  logic en0, en1, en2, en_a, div_in_ready, div_out_valid, sc_in_ready;
  logic v0_r, v1_r, v2_r, va_r;
  cmd_t cmd0_r, cmd1_r;
  logic [CNT_W-1:0] ii0_r, jj0_r, ii1_r, jj1_r;
  logic [CNT_W-1:0] ii0_nxt, jj0_nxt, seg_max, side_max;
  logic signed [PROD_W-1:0] prod1_r, prod1_nxt;
  logic [18:0]      a_full;
  logic [IDX_W-1:0] a1_r;
  logic [PROD_W-1:0] mag;
  logic [NUM_W-1:0] num2_r [DIV_LANES];
  div_side_t        side2_r, div_side;
  logic [NUM_W-1:0] quo [DIV_LANES];
  logic [ANG_W-1:0] tq, ta, ang_r [SC_LANES];
  vtx_side_t        sidea_r;

  assign seg_max  = seg_cnt - 1'b1;
  assign side_max = side_cnt - 1'b1;

  always_comb begin
    if (cmd_t'(in_command) == CMD_QUAD) begin
      ii0_nxt = (in_ring_index > seg_max)  ? seg_max  : in_ring_index;
      jj0_nxt = (in_side_index > side_max) ? side_max : in_side_index;
    end else begin
      ii0_nxt = (in_ring_index > seg_cnt)  ? seg_cnt  : in_ring_index;
      jj0_nxt = (in_side_index > side_cnt) ? side_cnt : in_side_index;
    end
    prod1_nxt = diff_r * $signed({1'b0, ii0_r});
    a_full    = 19'(ii0_r) * 19'(row) + 19'(jj0_r);
    mag       = prod1_r[PROD_W-1] ? PROD_W'(-prod1_r) : PROD_W'(prod1_r);
    tq        = quo[LANE_T][ANG_W-1:0];
    // truncation toward zero: subtract the magnitude quotient for a negative sweep
    ta        = start_r[ANG_W-1:0] + (div_side.neg ? -tq : tq);
  end

  assign en_a = !va_r || sc_in_ready;
  assign en2  = !v2_r || div_in_ready;
  assign en1  = !v1_r || en2;
  assign en0  = !v0_r || en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      va_r <= 1'b0;
    end else begin
      if (en0)  v0_r <= in_valid;
      if (en1)  v1_r <= v0_r;
      if (en2)  v2_r <= v1_r;
      if (en_a) va_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      cmd0_r <= cmd_t'(in_command);
      ii0_r  <= ii0_nxt;
      jj0_r  <= jj0_nxt;
    end
    if (en1) begin
      cmd1_r  <= cmd0_r;
      prod1_r <= prod1_nxt;
      a1_r    <= a_full[IDX_W-1:0];
      ii1_r   <= ii0_r;
      jj1_r   <= jj0_r;
    end
    if (en2) begin
      side2_r.cmd   <= cmd1_r;
      side2_r.idx_a <= a1_r;
      side2_r.idx_c <= a1_r + IDX_W'(row);
      side2_r.neg   <= prod1_r[PROD_W-1];
      num2_r[LANE_T] <= NUM_W'(mag);
      num2_r[LANE_U] <= NUM_W'({ii1_r, 16'b0});
      num2_r[LANE_V] <= NUM_W'({jj1_r, 16'b0});
    end
    if (en_a) begin
      sidea_r.cmd     <= div_side.cmd;
      sidea_r.idx_a   <= div_side.idx_a;
      sidea_r.idx_c   <= div_side.idx_c;
      sidea_r.tex_u   <= quo[LANE_U][TEX_W-1:0];
      sidea_r.tex_v   <= quo[LANE_V][TEX_W-1:0];
      ang_r[LANE_CT]  <= ta + ANG_W'(SIN_QTR);
      ang_r[LANE_ST]  <= ta;
      ang_r[LANE_CP]  <= quo[LANE_V][ANG_W-1:0] + ANG_W'(SIN_QTR);
      ang_r[LANE_SP]  <= quo[LANE_V][ANG_W-1:0];
    end
  end

  logic [DEN_W-1:0] dens [DIV_LANES];
  assign dens[LANE_T] = seg_cnt;
  assign dens[LANE_U] = seg_cnt;
  assign dens[LANE_V] = side_cnt;

  tamg_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (div_in_ready),
    .in_num    (num2_r),
    .den       (dens),
    .in_side   (side2_r),
    .out_valid (div_out_valid),
    .out_ready (en_a),
    .out_quo   (quo),
    .out_side  (div_side)
  );

  logic                     sc_out_valid, geo_in_ready;
  logic signed [NORM_W-1:0] trig [SC_LANES];
  vtx_side_t                sc_side;

  tamg_sincos u_sc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r),
    .in_ready  (sc_in_ready),
    .in_ang    (ang_r),
    .in_side   (sidea_r),
    .out_valid (sc_out_valid),
    .out_ready (geo_in_ready),
    .out_sin   (trig),
    .out_side  (sc_side)
  );

  logic                     geo_out_valid, out_take;
  logic signed [POS_W-1:0]  g_px, g_py, g_pz;
  logic signed [NORM_W-1:0] g_nx, g_ny, g_nz;
  vtx_side_t                g_side;

  tamg_geom u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sc_out_valid),
    .in_ready     (geo_in_ready),
    .in_trig      (trig),
    .in_side      (sc_side),
    .major_radius (major_r),
    .tube_radius  (tube_r),
    .out_valid    (geo_out_valid),
    .out_ready    (out_take),
    .pos_x        (g_px),
    .pos_y        (g_py),
    .pos_z        (g_pz),
    .norm_x       (g_nx),
    .norm_y       (g_ny),
    .norm_z       (g_nz),
    .out_side     (g_side)
  );

  // output register; a quad stays here for six results
  logic                     ov_r;
  cmd_t                     ocmd_r;
  logic [K_W-1:0]           k_r;
  logic signed [POS_W-1:0]  px_r, py_r, pz_r;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;
  logic [TEX_W-1:0]         u_r, v_r;
  logic [IDX_W-1:0]         ia_r, ic_r;
  logic                     last_w;
  logic                     is_quad;

  assign is_quad  = (g_side.cmd == CMD_QUAD);
  assign last_w   = (ocmd_r == CMD_VERTEX) || (k_r == K_W'(QUAD_LAST));
  assign out_take = !ov_r || (!out_stall && last_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else if (out_take) begin
      ov_r <= geo_out_valid;
      k_r  <= '0;
    end else if (!out_stall) begin
      k_r  <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      ocmd_r <= g_side.cmd;
      px_r   <= is_quad ? '0 : g_px;
      py_r   <= is_quad ? '0 : g_py;
      pz_r   <= is_quad ? '0 : g_pz;
      nx_r   <= is_quad ? '0 : g_nx;
      ny_r   <= is_quad ? '0 : g_ny;
      nz_r   <= is_quad ? '0 : g_nz;
      u_r    <= is_quad ? '0 : g_side.tex_u;
      v_r    <= is_quad ? '0 : g_side.tex_v;
      ia_r   <= g_side.idx_a;
      ic_r   <= g_side.idx_c;
    end
  end

  // triangle order a, c, b, b, c, d
  always_comb begin
    out_vertex_index = '0;
    if (ocmd_r == CMD_QUAD) begin
      case (k_r)
        3'd0:    out_vertex_index = ia_r;
        3'd1:    out_vertex_index = ic_r;
        3'd2:    out_vertex_index = ia_r + 1'b1;
        3'd3:    out_vertex_index = ia_r + 1'b1;
        3'd4:    out_vertex_index = ic_r;
        3'd5:    out_vertex_index = ic_r + 1'b1;
        default: out_vertex_index = '0;
      endcase
    end
  end

  assign in_stall   = !en0;
  assign out_valid  = ov_r;
  assign out_last   = last_w;
  assign out_pos_x  = px_r;
  assign out_pos_y  = py_r;
  assign out_pos_z  = pz_r;
  assign out_norm_x = nx_r;
  assign out_norm_y = ny_r;
  assign out_norm_z = nz_r;
  assign out_tex_u  = u_r;
  assign out_tex_v  = v_r;

endmodule

FILE: sv/tamg_checker.sv
// ----------------------------------------------------------------------------
// tamg_checker
// Port-level checks of the torus arc mesh generator, bound to the top level.
// ----------------------------------------------------------------------------
module tamg_checker
  import tamg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [POS_W-1:0]  out_pos_x,
  input logic signed [POS_W-1:0]  out_pos_y,
  input logic signed [POS_W-1:0]  out_pos_z,
  input logic signed [NORM_W-1:0] out_norm_z,
  input logic [TEX_W-1:0]         out_tex_u,
  input logic [TEX_W-1:0]         out_tex_v,
  input logic [IDX_W-1:0]         out_vertex_index,
  input logic                     out_last
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its index
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_index) && $stable(out_last))
    else $error("stalled result changed");

  // a quad's six results come without gaps
  a_quad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("quad results interrupted");

  // non-final results belong to quads and carry zero position, normal z and texture
  a_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0 &&
                               out_norm_z == 0 && out_tex_u == 0 && out_tex_v == 0)
    else $error("quad result with vertex attributes");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_z >= -16'sd16384 && out_norm_z <= 16'sd16384)
    else $error("normal out of range");

endmodule

bind torus_arc_mesh_generator tamg_checker u_tamg_checker (.*);
